/* sv/lj_pair_force_core_assert.svh */
// Assertion macros for the Lennard-Jones pair force core
`ifndef LJ_PAIR_FORCE_CORE_ASSERT_SVH
`define LJ_PAIR_FORCE_CORE_ASSERT_SVH
`ifndef SYNTH
`define LPF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LPF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPF_ASSERT(lbl, clk, rstn, prop, msg)
`define LPF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* sv/lpf_pkg.sv */
// Types and constants shared by the Lennard-Jones pair force core
package lpf_pkg;

    localparam int MAG_W   = 63;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [MAG_W-1:0]  CAP           = {MAG_W{1'b1}};
    localparam logic [MAG_W-1:0]  TM_CAP        = 63'h0001_0000_0000_0000;
    localparam logic signed [49:0] E_MAX        = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] E_MIN        = -50'sh0_8000_0000_0000;
    localparam logic [30:0]       CUTOFF_RESET  = 31'd163840;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_ISSUE,
        ENG_WAIT,
        ENG_DONE
    } eng_state_t;

    typedef enum logic [3:0] {
        STEP_S,
        STEP_S2,
        STEP_S3,
        STEP_S6,
        STEP_S12,
        STEP_TM,
        STEP_CM,
        STEP_D1,
        STEP_D2,
        STEP_FX,
        STEP_FY,
        STEP_FZ
    } step_t;

    // one classified pair as it waits in the queue
    typedef struct packed {
        logic [31:0] rel_x;
        logic [31:0] rel_y;
        logic [31:0] rel_z;
        logic [30:0] distance;
        logic [30:0] well_depth;
        logic [30:0] contact_radius;
        logic        clear_energy;
        logic        zero_dist;
        logic        in_cut;
    } job_t;

    typedef struct packed {
        logic [31:0] force_x;
        logic [31:0] force_y;
        logic [31:0] force_z;
        logic [47:0] energy_total;
        logic        saturated;
        logic        zero_distance;
    } result_t;

endpackage

/* sv/lpf_mul.sv */
// Multi-cycle 63x63 fixed-point multiplier built from 32x32 partial products
module lpf_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [lpf_pkg::MAG_W-1:0] op_a,
    input  logic [lpf_pkg::MAG_W-1:0] op_b,
    output logic                     done,
    output logic [lpf_pkg::MAG_W-1:0] res,
    output logic                     sat
);
    logic [62:0]  a_reg, b_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg, done_reg, pp_vld_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   sh_reg;
    logic [125:0] acc_reg;
    logic [31:0]  pa, pb;
    logic [125:0] pp_shifted;

    assign pa = cnt_reg[1] ? {1'b0, a_reg[62:32]} : a_reg[31:0];
    assign pb = cnt_reg[0] ? {1'b0, b_reg[62:32]} : b_reg[31:0];

    always_comb begin
        case (sh_reg) inside
            2'd0:       pp_shifted = {62'd0, pp_reg};
            2'd1, 2'd2: pp_shifted = {30'd0, pp_reg, 32'd0};
            default:    pp_shifted = {pp_reg[61:0], 64'd0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            pp_vld_reg <= 1'b0;
            cnt_reg    <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg      <= op_a;
                b_reg      <= op_b;
                acc_reg    <= '0;
                cnt_reg    <= 3'd0;
                busy_reg   <= 1'b1;
                pp_vld_reg <= 1'b0;
            end else if (busy_reg) begin
                if (cnt_reg < 3'd4) begin
                    pp_reg     <= pa * pb;
                    sh_reg     <= cnt_reg[1:0];
                    pp_vld_reg <= 1'b1;
                end else begin
                    pp_vld_reg <= 1'b0;
                end
                if (pp_vld_reg) begin
                    acc_reg <= acc_reg + pp_shifted;
                end
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign sat  = |acc_reg[125:FRAC_BITS+63];
    assign res  = sat ? lpf_pkg::CAP : acc_reg[FRAC_BITS+62:FRAC_BITS];
    assign done = done_reg;
endmodule

/* sv/lpf_div.sv */
// Bit-serial divider forming (num << F) / den, saturating at 2^63-1
module lpf_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [lpf_pkg::MAG_W-1:0] num,
    input  logic [30:0]               den,
    output logic                      done,
    output logic [lpf_pkg::MAG_W-1:0] quo,
    output logic                      sat
);
    logic [30:0] rem_reg;
    logic [62:0] sh_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg, sat_reg;
    logic [30:0] top_ext;
    logic [31:0] trial;
    logic        fits;

    // part of the shifted dividend above bit 62; quotient overflows if it reaches den
    assign top_ext = {{(31-FRAC_BITS){1'b0}}, num[62:63-FRAC_BITS]};
    assign trial   = {rem_reg, sh_reg[62]};
    assign fits    = trial >= {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (top_ext >= den) begin
                    sat_reg  <= 1'b1;
                    sh_reg   <= lpf_pkg::CAP;
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end else begin
                    sat_reg  <= 1'b0;
                    rem_reg  <= top_ext;
                    sh_reg   <= {num[62-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
                    cnt_reg  <= 6'd63;
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                rem_reg <= fits ? 31'(trial - {1'b0, den}) : trial[30:0];
                sh_reg  <= {sh_reg[61:0], fits};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = sh_reg;
    assign sat  = sat_reg;
endmodule

/* sv/lpf_queue.sv */
// Short queue between the front end and the arithmetic engine
module lpf_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lpf_pkg::job_t   push_job,
    output logic            full,
    input  logic            pop,
    output lpf_pkg::job_t   pop_job,
    output logic            not_empty
);
    lpf_pkg::job_t                   mem [lpf_pkg::Q_DEPTH];
    logic [lpf_pkg::Q_PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [lpf_pkg::Q_CNT_W-1:0]     cnt_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign pop_job   = mem[rd_ptr_reg];
    assign full      = cnt_reg == lpf_pkg::Q_CNT_W'(lpf_pkg::Q_DEPTH);
    assign not_empty = cnt_reg != '0;
endmodule

/* sv/lpf_front.sv */
// Front end: takes pair requests, holds the cutoff register, classifies pairs
module lpf_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [191:0]  s_tdata,
    input  logic          s_tuser,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [30:0]   cfg_data,
    input  logic          q_full,
    output logic          push,
    output lpf_pkg::job_t job
);
    logic [30:0] cutoff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= lpf_pkg::CUTOFF_RESET;
        end else if (cfg_valid) begin
            cutoff_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign push      = s_tvalid && !q_full;

    always_comb begin
        job.rel_x          = s_tdata[31:0];
        job.rel_y          = s_tdata[63:32];
        job.rel_z          = s_tdata[95:64];
        job.distance       = s_tdata[126:96];
        job.well_depth     = s_tdata[157:127];
        job.contact_radius = s_tdata[188:158];
        job.clear_energy   = s_tuser;
        job.zero_dist      = s_tdata[126:96] == 31'd0;
        job.in_cut         = s_tdata[126:96] <= cutoff_reg;
    end
endmodule

/* sv/lpf_engine.sv */
// Back end: sequences the shared divider and multiplier over one pair
`include "lj_pair_force_core_assert.svh"
module lpf_engine #(
    parameter int FRAC_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             job_valid,
    input  lpf_pkg::job_t    job,
    output logic             pop,
    output logic             res_valid,
    input  logic             res_ready,
    output lpf_pkg::result_t res
);
    lpf_pkg::eng_state_t state_reg, state_next;
    lpf_pkg::step_t      step_reg, step_next;
    lpf_pkg::job_t       job_reg;

    logic [62:0] s_reg, p_reg, s6_reg, s12_reg, cm_reg;
    logic [47:0] energy_reg;
    logic [31:0] fx_reg, fy_reg, fz_reg;
    logic        sat_reg;

    logic        mul_start, div_start, mul_done, div_done, mul_sat, div_sat;
    logic [62:0] mul_a, mul_b, mul_res, div_num, div_res;

    // energy and force glue
    logic        tneg, gneg, mk_sat, a_sat, b_sat;
    logic [62:0] dm, gm, a12, b6;
    logic [66:0] a12_w, b6_w;
    logic [33:0] e4;
    logic        tm_sat;
    logic [48:0] tm_c;
    logic signed [49:0] e_sum;
    logic [47:0] e_new;
    logic        e_sat;
    logic [31:0] fld;
    logic        rneg, fneg, f_sat;
    logic [31:0] rmag, fval;

    assign e4     = {1'b0, job_reg.well_depth, 2'b00};
    assign tneg   = s12_reg < s6_reg;
    assign dm     = tneg ? s6_reg - s12_reg : s12_reg - s6_reg;
    assign a12_w  = {1'b0, s12_reg, 3'b000} + {2'b00, s12_reg, 2'b00};
    assign b6_w   = {2'b00, s6_reg, 2'b00} + {3'b000, s6_reg, 1'b0};
    assign a_sat  = |a12_w[66:63];
    assign b_sat  = |b6_w[66:63];
    assign a12    = a_sat ? lpf_pkg::CAP : a12_w[62:0];
    assign b6     = b_sat ? lpf_pkg::CAP : b6_w[62:0];
    assign mk_sat = a_sat || b_sat;
    assign gneg   = a12 < b6;
    assign gm     = gneg ? b6 - a12 : a12 - b6;

    always_comb begin
        case (step_reg)
            lpf_pkg::STEP_FY: fld = job_reg.rel_y;
            lpf_pkg::STEP_FZ: fld = job_reg.rel_z;
            default:          fld = job_reg.rel_x;
        endcase
    end
    assign rneg = fld[31];
    assign rmag = rneg ? 32'(33'h1_0000_0000 - {1'b0, fld}) : fld;

    always_comb begin
        case (step_reg)
            lpf_pkg::STEP_S2:  begin mul_a = s_reg;        mul_b = s_reg;          end
            lpf_pkg::STEP_S3:  begin mul_a = p_reg;        mul_b = s_reg;          end
            lpf_pkg::STEP_S6:  begin mul_a = p_reg;        mul_b = p_reg;          end
            lpf_pkg::STEP_S12: begin mul_a = s6_reg;       mul_b = s6_reg;         end
            lpf_pkg::STEP_TM:  begin mul_a = {29'd0, e4};  mul_b = dm;             end
            lpf_pkg::STEP_CM:  begin mul_a = {29'd0, e4};  mul_b = gm;             end
            default:           begin mul_a = cm_reg;       mul_b = {31'd0, rmag};  end
        endcase
    end
    assign div_num = (step_reg == lpf_pkg::STEP_S) ? {32'd0, job_reg.contact_radius} : cm_reg;

    // energy update from the clipped term
    assign tm_sat = mul_res > lpf_pkg::TM_CAP;
    assign tm_c   = tm_sat ? lpf_pkg::TM_CAP[48:0] : mul_res[48:0];
    always_comb begin
        e_sum = {{2{energy_reg[47]}}, energy_reg}
              + (tneg ? -$signed({1'b0, tm_c}) : $signed({1'b0, tm_c}));
        e_sat = 1'b0;
        e_new = e_sum[47:0];
        if (e_sum > lpf_pkg::E_MAX) begin
            e_sat = 1'b1;
            e_new = lpf_pkg::E_MAX[47:0];
        end else if (e_sum < lpf_pkg::E_MIN) begin
            e_sat = 1'b1;
            e_new = lpf_pkg::E_MIN[47:0];
        end
    end

    // force component with sign and clipping
    assign fneg = gneg ^ rneg;
    always_comb begin
        f_sat = 1'b0;
        if (fneg) begin
            if (mul_res > 63'h8000_0000) begin
                f_sat = 1'b1;
                fval  = 32'h8000_0000;
            end else begin
                fval = 32'(33'h1_0000_0000 - {1'b0, mul_res[31:0]});
            end
        end else begin
            if (mul_res > 63'h7FFF_FFFF) begin
                f_sat = 1'b1;
                fval  = 32'h7FFF_FFFF;
            end else begin
                fval = mul_res[31:0];
            end
        end
    end

    lpf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .op_a(mul_a), .op_b(mul_b), .done(mul_done), .res(mul_res), .sat(mul_sat)
    );

    lpf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(job_reg.distance), .done(div_done), .quo(div_res), .sat(div_sat)
    );

    logic is_div_step;
    assign is_div_step = (step_reg == lpf_pkg::STEP_S) || (step_reg == lpf_pkg::STEP_D1)
                      || (step_reg == lpf_pkg::STEP_D2);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        pop        = 1'b0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        res_valid  = 1'b0;
        unique case (state_reg)
            lpf_pkg::ENG_IDLE: begin
                if (job_valid) begin
                    pop        = 1'b1;
                    step_next  = lpf_pkg::STEP_S;
                    state_next = job.zero_dist ? lpf_pkg::ENG_DONE : lpf_pkg::ENG_ISSUE;
                end
            end
            lpf_pkg::ENG_ISSUE: begin
                div_start  = is_div_step;
                mul_start  = !is_div_step;
                state_next = lpf_pkg::ENG_WAIT;
            end
            lpf_pkg::ENG_WAIT: begin
                if (mul_done || div_done) begin
                    state_next = lpf_pkg::ENG_ISSUE;
                    unique case (step_reg)
                        lpf_pkg::STEP_S:   step_next = lpf_pkg::STEP_S2;
                        lpf_pkg::STEP_S2:  step_next = lpf_pkg::STEP_S3;
                        lpf_pkg::STEP_S3:  step_next = lpf_pkg::STEP_S6;
                        lpf_pkg::STEP_S6:  step_next = lpf_pkg::STEP_S12;
                        lpf_pkg::STEP_S12: step_next = lpf_pkg::STEP_TM;
                        lpf_pkg::STEP_TM: begin
                            step_next = lpf_pkg::STEP_CM;
                            if (!job_reg.in_cut) state_next = lpf_pkg::ENG_DONE;
                        end
                        lpf_pkg::STEP_CM:  step_next = lpf_pkg::STEP_D1;
                        lpf_pkg::STEP_D1:  step_next = lpf_pkg::STEP_D2;
                        lpf_pkg::STEP_D2:  step_next = lpf_pkg::STEP_FX;
                        lpf_pkg::STEP_FX:  step_next = lpf_pkg::STEP_FY;
                        lpf_pkg::STEP_FY:  step_next = lpf_pkg::STEP_FZ;
                        default:           state_next = lpf_pkg::ENG_DONE;
                    endcase
                end
            end
            lpf_pkg::ENG_DONE: begin
                res_valid = 1'b1;
                if (res_ready) state_next = lpf_pkg::ENG_IDLE;
            end
            default: state_next = lpf_pkg::ENG_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= lpf_pkg::ENG_IDLE;
            step_reg   <= lpf_pkg::STEP_S;
            energy_reg <= '0;
            sat_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (pop) begin
                job_reg <= job;
                sat_reg <= 1'b0;
                fx_reg  <= '0;
                fy_reg  <= '0;
                fz_reg  <= '0;
                if (job.clear_energy) energy_reg <= '0;
            end else if (state_reg == lpf_pkg::ENG_WAIT && (mul_done || div_done)) begin
                case (step_reg)
                    lpf_pkg::STEP_S: begin
                        s_reg   <= div_res;
                        sat_reg <= sat_reg | div_sat;
                    end
                    lpf_pkg::STEP_S2, lpf_pkg::STEP_S3: begin
                        p_reg   <= mul_res;
                        sat_reg <= sat_reg | mul_sat;
                    end
                    lpf_pkg::STEP_S6: begin
                        s6_reg  <= mul_res;
                        sat_reg <= sat_reg | mul_sat;
                    end
                    lpf_pkg::STEP_S12: begin
                        s12_reg <= mul_res;
                        sat_reg <= sat_reg | mul_sat;
                    end
                    lpf_pkg::STEP_TM: begin
                        energy_reg <= e_new;
                        sat_reg    <= sat_reg | mul_sat | tm_sat | e_sat
                                    | (job_reg.in_cut && mk_sat);
                    end
                    lpf_pkg::STEP_CM: begin
                        cm_reg  <= mul_res;
                        sat_reg <= sat_reg | mul_sat;
                    end
                    lpf_pkg::STEP_D1, lpf_pkg::STEP_D2: begin
                        cm_reg  <= div_res;
                        sat_reg <= sat_reg | div_sat;
                    end
                    lpf_pkg::STEP_FX: begin
                        fx_reg  <= fval;
                        sat_reg <= sat_reg | mul_sat | f_sat;
                    end
                    lpf_pkg::STEP_FY: begin
                        fy_reg  <= fval;
                        sat_reg <= sat_reg | mul_sat | f_sat;
                    end
                    default: begin
                        fz_reg  <= fval;
                        sat_reg <= sat_reg | mul_sat | f_sat;
                    end
                endcase
            end
        end
    end

    always_comb begin
        res.force_x       = fx_reg;
        res.force_y       = fy_reg;
        res.force_z       = fz_reg;
        res.energy_total  = energy_reg;
        res.saturated     = sat_reg;
        res.zero_distance = job_reg.zero_dist;
    end

    `LPF_ASSERT(a_units_quiet_idle, aclk, aresetn, (state_reg == lpf_pkg::ENG_IDLE) |-> (!mul_done && !div_done), "arithmetic unit finished while engine idle")
    `LPF_ASSERT(a_zero_dist_clean, aclk, aresetn, (res_valid && job_reg.zero_dist) |-> (fx_reg == 32'd0 && fy_reg == 32'd0 && fz_reg == 32'd0 && !sat_reg), "zero distance pair left force or flag set")
    `LPF_ASSERT(a_pop_starts_work, aclk, aresetn, pop |=> (state_reg == lpf_pkg::ENG_ISSUE || state_reg == lpf_pkg::ENG_DONE), "queue pop did not start a pair")
endmodule

/* sv/lj_pair_force_core.sv */
// Top level of the Lennard-Jones 12-6 pair force and energy core
// Lennard-Jones 12-6 pair force core. Each request on the s_ stream is one particle
// pair (separation vector, distance, epsilon, sigma, all Q(32-F).F) and yields exactly
// one result on the m_ stream: the force vector, zero beyond the cutoff or at zero
// distance, the running energy sum after this pair, and sticky saturation and zero-distance
// flags. Pairs are taken into a two-entry queue by the front end while the engine works,
// so a new request is accepted whilst an earlier one is in flight. The engine handles one
// pair at a time: it drives one bit-serial divider and one 32x32 partial-product
// multiplier, which forms 63-bit products, through s = sigma/d, s^2, s^3, s^6, s^12,
// the energy term, then inside the cutoff the force coefficient, two divisions by d and
// three component products; a zero-distance pair skips the arithmetic. Most of the time
// of a pair is spent in the divider. The cutoff register must be written on the cfg
// channel only while the core is idle; the core itself does not enforce this. The
// register resets to 2.5 in Q16.16.
module lj_pair_force_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // pair request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // rel_x[31:0] rel_y[63:32] rel_z[95:64] distance[126:96]
                                    // well_depth[157:127] contact_radius[188:158] zero[191:189]
    input  logic         s_tuser,   // clear_energy[0]
    // cutoff register write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [30:0]  cfg_data,  // cutoff_radius
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // force_x[31:0] force_y[63:32] force_z[95:64]
                                    // energy_total[143:96]
    output logic [1:0]   m_tuser    // saturated[0] zero_distance[1]
);
    lpf_pkg::job_t    push_job, pop_job;
    lpf_pkg::result_t eng_res;
    logic             q_full, q_push, q_pop, q_not_empty;
    logic             res_valid, res_ready;

    // output register
    logic             out_valid_reg;
    lpf_pkg::result_t out_reg;

    lpf_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .q_full(q_full), .push(q_push), .job(push_job)
    );

    lpf_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_job(push_job), .full(q_full),
        .pop(q_pop), .pop_job(pop_job), .not_empty(q_not_empty)
    );

    lpf_engine #(.FRAC_BITS(FRAC_BITS)) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(q_not_empty), .job(pop_job), .pop(q_pop),
        .res_valid(res_valid), .res_ready(res_ready), .res(eng_res)
    );

    // engine hands over as soon as the output slot is free or being emptied
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= eng_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.energy_total, out_reg.force_z, out_reg.force_y, out_reg.force_x};
    assign m_tuser  = {out_reg.zero_distance, out_reg.saturated};
endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the Lennard-Jones pair force core
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam logic [63:0] CAP64 = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] rel_x;
        logic [31:0] rel_y;
        logic [31:0] rel_z;
        logic [30:0] distance;
        logic [30:0] well_depth;
        logic [30:0] contact_radius;
        logic        clear_energy;
    } pair_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [30:0]  cfg_data = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic [1:0]   m_tuser;

    always #4 aclk = ~aclk;

    lj_pair_force_core #(.FRAC_BITS(FB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // predictor state
    logic signed [47:0] energy_acc;
    logic [30:0]        cutoff_q;
    lpf_pkg::result_t   force_q[$];
    int                 mismatches = 0;
    bit                 calm = 1'b0;
    bit                 hold_req = 1'b0;

    // truncated Q product, clipped at the 63-bit cap
    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b, ref bit sat);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> FB;
        if (p > {64'd0, CAP64}) begin
            sat = 1'b1;
            return CAP64;
        end
        return p[63:0];
    endfunction

    function automatic logic [63:0] qdiv(logic [63:0] a, logic [63:0] b, ref bit sat);
        logic [63:0] q, r;
        q = a / b;
        r = a % b;
        if (q > (CAP64 >> FB)) begin
            sat = 1'b1;
            return CAP64;
        end
        return (q << FB) + (r << FB) / b;
    endfunction

    function automatic logic [63:0] kmul(logic [63:0] a, logic [63:0] k, ref bit sat);
        if (a > CAP64 / k) begin
            sat = 1'b1;
            return CAP64;
        end
        return a * k;
    endfunction

    function automatic logic [31:0] comp_force(logic [63:0] cm, bit cneg, logic [31:0] v,
                                               ref bit sat);
        bit          rneg;
        logic [63:0] rm, m;
        rneg = v[31];
        rm = rneg ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
        m = qmul(cm, rm, sat);
        if (cneg ^ rneg) begin
            if (m > 64'h8000_0000) begin
                sat = 1'b1;
                m = 64'h8000_0000;
            end
            return 32'(64'h1_0000_0000 - m);
        end
        if (m > 64'h7FFF_FFFF) begin
            sat = 1'b1;
            m = 64'h7FFF_FFFF;
        end
        return m[31:0];
    endfunction

    // force and energy of one pair, updating the running sum
    function automatic lpf_pkg::result_t lj_predict(pair_t p);
        lpf_pkg::result_t r;
        bit sat;
        logic [63:0] d, s, s2, s3, s6, s12, e4, dm, tm, a, b, gm, cm;
        bit tneg, gneg;
        logic signed [63:0] e;
        sat = 1'b0;
        r = '0;
        d = {33'd0, p.distance};
        if (p.clear_energy) energy_acc = '0;
        if (d == 0) begin
            r.zero_distance = 1'b1;
        end else begin
            s   = ({33'd0, p.contact_radius} << FB) / d;
            s2  = qmul(s, s, sat);
            s3  = qmul(s2, s, sat);
            s6  = qmul(s3, s3, sat);
            s12 = qmul(s6, s6, sat);
            e4  = {33'd0, p.well_depth} * 4;
            tneg = s12 < s6;
            dm  = tneg ? s6 - s12 : s12 - s6;
            tm  = qmul(e4, dm, sat);
            if (tm > 64'h0001_0000_0000_0000) begin
                sat = 1'b1;
                tm = 64'h0001_0000_0000_0000;
            end
            e = 64'(energy_acc) + (tneg ? -$signed(tm) : $signed(tm));
            if (e > 64'sh0000_7FFF_FFFF_FFFF) begin
                sat = 1'b1;
                e = 64'sh0000_7FFF_FFFF_FFFF;
            end
            if (e < -64'sh0000_8000_0000_0000) begin
                sat = 1'b1;
                e = -64'sh0000_8000_0000_0000;
            end
            energy_acc = e[47:0];
            if (p.distance <= cutoff_q) begin
                a = kmul(s12, 12, sat);
                b = kmul(s6, 6, sat);
                gneg = a < b;
                gm = gneg ? b - a : a - b;
                cm = qmul(e4, gm, sat);
                cm = qdiv(cm, d, sat);
                cm = qdiv(cm, d, sat);
                r.force_x = comp_force(cm, gneg, p.rel_x, sat);
                r.force_y = comp_force(cm, gneg, p.rel_y, sat);
                r.force_z = comp_force(cm, gneg, p.rel_z, sat);
            end
        end
        r.energy_total = energy_acc;
        r.saturated = sat;
        return r;
    endfunction

    function automatic pair_t mk_pair(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      logic [30:0] d, logic [30:0] e, logic [30:0] s, bit c);
        pair_t p;
        p = '{x, y, z, d, e, s, c};
        return p;
    endfunction

    // mostly physical pairs near the well, a share of raw noise
    function automatic pair_t rand_pair();
        pair_t p;
        int    dd;
        if ($urandom_range(99) < 85) begin
            dd = $urandom_range(32'h3_C000, 32'h4000);
            p.distance = 31'(dd);
            p.rel_x = 32'($signed($urandom_range(2 * dd)) - dd);
            p.rel_y = 32'($signed($urandom_range(2 * dd)) - dd);
            p.rel_z = 32'($signed($urandom_range(2 * dd)) - dd);
            p.well_depth = 31'($urandom_range(32'h3_0000));
            p.contact_radius = 31'($urandom_range(32'h1_8000, 32'h8000));
            p.clear_energy = ($urandom_range(19) == 0);
        end else begin
            p.rel_x = $urandom;
            p.rel_y = $urandom;
            p.rel_z = $urandom;
            p.distance = ($urandom_range(7) == 0) ? 31'd0 : 31'($urandom);
            p.well_depth = 31'($urandom);
            p.contact_radius = 31'($urandom);
            p.clear_energy = 1'($urandom_range(1));
        end
        return p;
    endfunction

    // one request on the pair stream; hold tvalid across back-to-back items
    task automatic send_pair(pair_t p, bit typed, lpf_pkg::result_t want);
        lpf_pkg::result_t got;
        if (!calm && $urandom_range(3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, p.contact_radius, p.well_depth, p.distance,
                     p.rel_z, p.rel_y, p.rel_x};
        s_tuser  <= p.clear_energy;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        got = lj_predict(p);
        force_q.push_back(typed ? want : got);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (force_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_cutoff(logic [30:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        cutoff_q = v;
    endtask

    // result side: random back-pressure, one long hold-off on request
    always @(posedge aclk) begin : result_sink
        static int hold = 0;
        static bit held = 1'b0;
        lpf_pkg::result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.force_x       = m_tdata[31:0];
            got.force_y       = m_tdata[63:32];
            got.force_z       = m_tdata[95:64];
            got.energy_total  = m_tdata[143:96];
            got.saturated     = m_tuser[0];
            got.zero_distance = m_tuser[1];
            if (force_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = force_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: fx %h/%h fy %h/%h fz %h/%h e %h/%h sat %b/%b zd %b/%b",
                                 want.force_x, got.force_x, want.force_y, got.force_y,
                                 want.force_z, got.force_z, want.energy_total,
                                 got.energy_total, want.saturated, got.saturated,
                                 want.zero_distance, got.zero_distance);
                end
            end
        end
        if (hold_req && !held) begin
            hold = 3000;
            held = 1'b1;
        end
        if (hold > 0) begin
            hold--;
            m_tready <= 1'b0;
        end else if (calm || !aresetn) begin
            m_tready <= 1'b1;
        end else if (!m_tready) begin
            m_tready <= ($urandom_range(5) == 0);
        end else begin
            m_tready <= ($urandom_range(9) != 0);
        end
    end

    initial begin : limit
        #60ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        pair_t            dir[14];
        lpf_pkg::result_t zd_want;
        energy_acc = '0;
        cutoff_q = lpf_pkg::CUTOFF_RESET;
        zd_want = '0;
        zd_want.zero_distance = 1'b1;
        // zero distance, extremes, cutoff edges, tiny and huge ratios
        dir[0]  = mk_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 31'd0, 31'h7FFF_FFFF,
                          31'h7FFF_FFFF, 1'b1);
        dir[1]  = mk_pair(32'h1_0000, 32'h0, 32'h0, 31'h1_0000, 31'h1_0000, 31'h1_0000, 1'b0);
        dir[2]  = mk_pair(32'h2_8000, 32'hFFFF_0000, 32'h0, 31'd163840, 31'h1_0000,
                          31'h1_0000, 1'b0);
        dir[3]  = mk_pair(32'h2_8000, 32'h0, 32'h1, 31'd163841, 31'h1_0000, 31'h1_0000, 1'b0);
        dir[4]  = mk_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'd1, 31'h1_0000,
                          31'h1_0000, 1'b0);
        dir[5]  = mk_pair(32'h1000, 32'h1000, 32'h1000, 31'd1, 31'd0, 31'h1_0000, 1'b1);
        dir[6]  = mk_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                          31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        dir[7]  = mk_pair(32'h1_0000, 32'h1_0000, 32'h0, 31'h1_6A0A, 31'h7FFF_FFFF,
                          31'h1_0000, 1'b0);
        dir[8]  = mk_pair(32'hFFFF_8000, 32'h0, 32'h0, 31'h8000, 31'h1_0000, 31'd0, 1'b0);
        dir[9]  = mk_pair(32'h0, 32'h0, 32'h1_0000, 31'h1_0000, 31'h1_0000, 31'h7FFF_FFFF,
                          1'b0);
        dir[10] = mk_pair(32'h1_2000, 32'hFFFF_0000, 32'h0, 31'h1_2000, 31'h2_0000,
                          31'h1_0000, 1'b1);
        dir[11] = mk_pair(32'hFFFF_FFFF, 32'h0, 32'h0, 31'h2_0000, 31'h1_0000, 31'h1_0000,
                          1'b0);
        dir[12] = mk_pair(32'h1, 32'h1, 32'h1, 31'd0, 31'd0, 31'd0, 1'b0);
        dir[13] = mk_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 31'h5555_5555,
                          31'h2AAA_AAAA, 31'h5555_5555, 1'b1);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset cutoff, directed table; only the opening zero-distance row is typed
        foreach (dir[i]) send_pair(dir[i], i == 0, zd_want);
        drain();

        write_cutoff(31'h7FFF_FFFF);
        repeat (400) send_pair(rand_pair(), 1'b0, zd_want);
        drain();

        // every pair of nonzero distance beyond the cutoff
        write_cutoff(31'd0);
        repeat (300) send_pair(rand_pair(), 1'b0, zd_want);
        drain();

        write_cutoff(31'($urandom_range(32'h4_0000, 32'h1_0000)));
        hold_req <= 1'b1;
        for (int i = 0; i < 850; i++) begin
            if (i == 650) calm = 1'b1;
            send_pair(rand_pair(), 1'b0, zd_want);
        end
        drain();
        repeat (400) @(posedge aclk);

        if (mismatches == 0 && force_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
